// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the lock RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types, codes and constants of the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

   // field widths fixed by the interface
   localparam int CODE_W    = 14;
   localparam int KEY_W     = 4;
   localparam int FAIL_W    = 4;
   localparam int DIGITS_W  = 3;
   localparam int EVENT_W   = 3;
   localparam int MOTOR_W   = 2;
   localparam int CSR_IDX_W = 2;

   // default number of digits in a code
   localparam int CODE_DIGITS_DEF = 4;

   // key codes
   localparam logic [KEY_W-1:0] KEY_ENTER     = 4'd10;
   localparam logic [KEY_W-1:0] KEY_DIGIT_MIN = 4'd1;
   localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;

   // failure counter saturation
   localparam logic [FAIL_W-1:0] FAIL_MAX = 4'd15;

   // register reset values
   localparam logic [CODE_W-1:0] OPEN_CODE_RST    = 14'd4321;
   localparam logic [CODE_W-1:0] CLOSE_CODE_RST   = 14'd8765;
   localparam logic [FAIL_W-1:0] MAX_FAILURES_RST = 4'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_CODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_CODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FAILURES = 2'd2;

   typedef enum logic [EVENT_W-1:0] {
      EVT_IGNORED = 3'd0,
      EVT_DIGIT   = 3'd1,
      EVT_FULL    = 3'd2,
      EVT_CORRECT = 3'd3,
      EVT_WRONG   = 3'd4,
      EVT_ALARM   = 3'd5
   } event_type;

   typedef enum logic [MOTOR_W-1:0] {
      MOTOR_NONE  = 2'd0,
      MOTOR_OPEN  = 2'd1,
      MOTOR_CLOSE = 2'd2
   } motor_type;

   // configuration registers as seen by the core
   typedef struct packed {
      logic [CODE_W-1:0] open_code;
      logic [CODE_W-1:0] close_code;
      logic [FAIL_W-1:0] max_failures;
   } cfg_type;

   // one result transaction
   typedef struct packed {
      event_type           evt;
      motor_type           motor;
      logic                locked;
      logic [DIGITS_W-1:0] digits;
      logic [FAIL_W-1:0]   failures;
   } result_type;

endpackage

// File: src/kcl_core.sv
// ----------------------------------------------------------------------------
// kcl_core
// Lock state and per-key update: entry buffers, failure counter, door state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kcl_core #(
   parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  kcl_pkg::cfg_type                 cfg,
   input  logic                             step_en,
   input  logic                             req_side,
   input  logic [kcl_pkg::KEY_W-1:0]        req_key,
   output kcl_pkg::result_type              res
);
   import kcl_pkg::*;

   localparam int ENTRY_W = $clog2(10 ** CODE_DIGITS);
   localparam int CNT_W   = $clog2(CODE_DIGITS + 1);
   localparam int CMP_W   = (ENTRY_W > CODE_W) ? ENTRY_W : CODE_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_DIGITS);

   // state registers
   logic               last_out_ff, last_out_in;
   logic [ENTRY_W-1:0] out_entry_ff, out_entry_in;
   logic [CNT_W-1:0]   out_cnt_ff, out_cnt_in;
   logic [ENTRY_W-1:0] in_entry_ff, in_entry_in;
   logic [CNT_W-1:0]   in_cnt_ff, in_cnt_in;
   logic [FAIL_W-1:0]  fail_ff, fail_in;
   logic               locked_ff, locked_in;

   // working values
   logic               now_out;
   logic               side_change;
   logic [ENTRY_W-1:0] cur_entry, new_entry;
   logic [CNT_W-1:0]   cur_cnt, new_cnt;
   logic [CODE_W-1:0]  code_sel;
   logic               match;
   logic               is_digit;
   logic [ENTRY_W+3:0] entry_x10;

   assign now_out     = ~req_side;
   assign side_change = (now_out != last_out_ff);
   assign cur_entry   = side_change ? '0 : (req_side ? in_entry_ff : out_entry_ff);
   assign cur_cnt     = side_change ? '0 : (req_side ? in_cnt_ff : out_cnt_ff);
   assign code_sel    = req_side ? cfg.close_code : cfg.open_code;
   assign match       = (cur_cnt == CNT_FULL) &&
                        (CMP_W'(cur_entry) == CMP_W'(code_sel));
   assign is_digit    = (req_key >= KEY_DIGIT_MIN) && (req_key <= KEY_DIGIT_MAX);

   // entry times ten plus the new digit
   assign entry_x10 = ((ENTRY_W+4)'(cur_entry) << 3) + ((ENTRY_W+4)'(cur_entry) << 1)
                      + (ENTRY_W+4)'(req_key);

   // key decode and next state
   always_comb begin
      new_entry  = cur_entry;
      new_cnt    = cur_cnt;
      fail_in    = fail_ff;
      locked_in  = locked_ff;
      res.evt    = EVT_IGNORED;
      res.motor  = MOTOR_NONE;
      if (req_key == KEY_ENTER) begin
         if (match) begin
            res.evt = EVT_CORRECT;
            if (!req_side && locked_ff) begin
               res.motor = MOTOR_OPEN;
               locked_in = 1'b0;
            end else if (req_side && !locked_ff) begin
               res.motor = MOTOR_CLOSE;
               locked_in = 1'b1;
            end
         end else begin
            res.evt   = EVT_WRONG;
            new_entry = '0;
            new_cnt   = '0;
            if (fail_ff != FAIL_MAX) begin
               fail_in = fail_ff + 1'b1;
            end
         end
      end else if (fail_ff >= cfg.max_failures) begin
         res.evt = EVT_ALARM;
         fail_in = '0;
      end else if (is_digit) begin
         if (cur_cnt < CNT_FULL) begin
            res.evt   = EVT_DIGIT;
            new_entry = entry_x10[ENTRY_W-1:0];
            new_cnt   = cur_cnt + 1'b1;
         end else begin
            res.evt = EVT_FULL;
         end
      end
      res.locked   = locked_in;
      res.digits   = DIGITS_W'(new_cnt);
      res.failures = fail_in;
   end

   // write back to the pressed side, clear the other side on a side change
   always_comb begin
      last_out_in  = now_out;
      out_entry_in = side_change ? '0 : out_entry_ff;
      out_cnt_in   = side_change ? '0 : out_cnt_ff;
      in_entry_in  = side_change ? '0 : in_entry_ff;
      in_cnt_in    = side_change ? '0 : in_cnt_ff;
      if (req_side) begin
         in_entry_in = new_entry;
         in_cnt_in   = new_cnt;
      end else begin
         out_entry_in = new_entry;
         out_cnt_in   = new_cnt;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_out_ff  <= 1'b0;
         out_entry_ff <= '0;
         out_cnt_ff   <= '0;
         in_entry_ff  <= '0;
         in_cnt_ff    <= '0;
         fail_ff      <= '0;
         locked_ff    <= 1'b1;
      end else if (step_en) begin
         last_out_ff  <= last_out_in;
         out_entry_ff <= out_entry_in;
         out_cnt_ff   <= out_cnt_in;
         in_entry_ff  <= in_entry_in;
         in_cnt_ff    <= in_cnt_in;
         fail_ff      <= fail_in;
         locked_ff    <= locked_in;
      end
   end

   // checks
   `ASSERT_IMPLIES(a_out_cnt_bound, clock, reset, 1'b1, out_cnt_ff <= CNT_FULL)
   `ASSERT_IMPLIES(a_in_cnt_bound, clock, reset, 1'b1, in_cnt_ff <= CNT_FULL)
   `ASSERT_IMPLIES(a_one_side, clock, reset, out_cnt_ff != '0, in_cnt_ff == '0)
   `ASSERT_NEXT(a_alarm_clr, clock, reset, step_en && (res.evt == EVT_ALARM), fail_ff == '0)
   `ASSERT_NEXT(a_open_door, clock, reset, step_en && (res.motor == MOTOR_OPEN), !locked_ff)

endmodule

// File: src/keypad_code_lock_top.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_top
// Two-sided keypad door lock with configurable codes and failure limit.
// ----------------------------------------------------------------------------
// A key transaction's result is registered and valid in the cycle after acceptance.
// Throughput: one key per cycle while rsp_ready holds; the result register frees as it is taken.
// The lock state updates in the same cycle as the result register loads.
// Reset: synchronous, active high; door locked, entries and failures cleared,
// codes back to 4321 / 8765 and failure limit 3.
// ----------------------------------------------------------------------------
module keypad_code_lock_top #(
   parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // key transactions
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_side,
   input  logic [kcl_pkg::KEY_W-1:0]        req_key,
   // result transactions
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [kcl_pkg::EVENT_W-1:0]      rsp_event_res,
   output logic [kcl_pkg::MOTOR_W-1:0]      rsp_motor_cmd,
   output logic                             rsp_door_locked,
   output logic [kcl_pkg::DIGITS_W-1:0]     rsp_digits_entered,
   output logic [kcl_pkg::FAIL_W-1:0]       rsp_failure_count,
   // configuration writes
   input  logic                             csr_wr_en,
   input  logic [kcl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kcl_pkg::CODE_W-1:0]       csr_wdata
);
   import kcl_pkg::*;

   cfg_type    cfg_ff;
   result_type res;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       step_en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_code    <= OPEN_CODE_RST;
         cfg_ff.close_code   <= CLOSE_CODE_RST;
         cfg_ff.max_failures <= MAX_FAILURES_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OPEN_CODE:    cfg_ff.open_code    <= csr_wdata;
            CSR_CLOSE_CODE:   cfg_ff.close_code   <= csr_wdata;
            CSR_MAX_FAILURES: cfg_ff.max_failures <= csr_wdata[FAIL_W-1:0];
            default: ;
         endcase
      end
   end

   // accept when the result register is empty or being drained
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign step_en   = req_valid & req_ready;

   kcl_core #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .step_en  (step_en),
      .req_side (req_side),
      .req_key  (req_key),
      .res      (res)
   );

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_ff.evt;
   assign rsp_motor_cmd      = rsp_ff.motor;
   assign rsp_door_locked    = rsp_ff.locked;
   assign rsp_digits_entered = rsp_ff.digits;
   assign rsp_failure_count  = rsp_ff.failures;

endmodule

// File: tb/keypad_code_lock_top_test.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_top_test
// Self-checking bench for the two-sided keypad lock. Key presses go in over
// the req_ channel and a local model of the lock predicts each rsp_
// transaction. The run starts with a directed key sequence and then moves
// through several code and failure-limit settings with mostly well-formed
// random code entries, random idling on both channels and a final
// stretch at full rate.
// ----------------------------------------------------------------------------
module keypad_code_lock_top_test;
   import kcl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   // register slot with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // lock model and store of predicted results
   class lock_scoreboard;
      logic [CODE_W-1:0] open_code    = OPEN_CODE_RST;
      logic [CODE_W-1:0] close_code   = CLOSE_CODE_RST;
      logic [FAIL_W-1:0] fail_limit   = MAX_FAILURES_RST;
      logic              last_outdoor = 1'b0;
      int unsigned       out_entry    = 0;
      int unsigned       out_digits   = 0;
      int unsigned       in_entry     = 0;
      int unsigned       in_digits    = 0;
      int unsigned       fail_cnt     = 0;
      logic              door_locked  = 1'b1;
      result_type        pending_results[$];
      int                mismatches   = 0;

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CODE_W-1:0] value);
         case (idx)
            CSR_OPEN_CODE:    open_code = value;
            CSR_CLOSE_CODE:   close_code = value;
            CSR_MAX_FAILURES: fail_limit = value[FAIL_W-1:0];
            default: ;
         endcase
      endfunction

      // advance the lock by one key press and queue its result
      function void note_press(logic side, logic [KEY_W-1:0] key);
         result_type  r;
         int unsigned entry;
         int unsigned digits;
         int unsigned code;
         if (!side != last_outdoor) begin
            last_outdoor = !side;
            out_entry = 0;
            out_digits = 0;
            in_entry = 0;
            in_digits = 0;
         end
         entry  = side ? in_entry : out_entry;
         digits = side ? in_digits : out_digits;
         code   = side ? close_code : open_code;
         r.evt   = EVT_IGNORED;
         r.motor = MOTOR_NONE;
         if (key == KEY_ENTER) begin
            if (digits == CODE_DIGITS_DEF && entry == code) begin
               r.evt = EVT_CORRECT;
               if (!side && door_locked) begin
                  r.motor = MOTOR_OPEN;
                  door_locked = 1'b0;
               end else if (side && !door_locked) begin
                  r.motor = MOTOR_CLOSE;
                  door_locked = 1'b1;
               end
            end else begin
               r.evt = EVT_WRONG;
               if (fail_cnt < FAIL_MAX) fail_cnt++;
               entry = 0;
               digits = 0;
            end
         end else if (fail_cnt >= fail_limit) begin
            r.evt = EVT_ALARM;
            fail_cnt = 0;
         end else if (key >= KEY_DIGIT_MIN && key <= KEY_DIGIT_MAX) begin
            if (digits < CODE_DIGITS_DEF) begin
               entry = entry * 10 + key;
               digits++;
               r.evt = EVT_DIGIT;
            end else begin
               r.evt = EVT_FULL;
            end
         end
         if (side) begin
            in_entry = entry;
            in_digits = digits;
         end else begin
            out_entry = entry;
            out_digits = digits;
         end
         r.locked   = door_locked;
         r.digits   = digits[DIGITS_W-1:0];
         r.failures = fail_cnt[FAIL_W-1:0];
         pending_results.push_back(r);
      endfunction

      // compare one result transaction with the oldest prediction
      function void check_result(logic [EVENT_W-1:0] evt, logic [MOTOR_W-1:0] motor,
                                 logic locked, logic [DIGITS_W-1:0] digits,
                                 logic [FAIL_W-1:0] failures);
         result_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction: event_res %0d", evt);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (evt !== want.evt) begin
            $error("event_res expected %0d actual %0d", want.evt, evt);
            mismatches++;
         end
         if (motor !== want.motor) begin
            $error("motor_cmd expected %0d actual %0d", want.motor, motor);
            mismatches++;
         end
         if (locked !== want.locked) begin
            $error("door_locked expected %0d actual %0d", want.locked, locked);
            mismatches++;
         end
         if (digits !== want.digits) begin
            $error("digits_entered expected %0d actual %0d", want.digits, digits);
            mismatches++;
         end
         if (failures !== want.failures) begin
            $error("failure_count expected %0d actual %0d", want.failures, failures);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_side  = 1'b0;
   logic [KEY_W-1:0]     req_key   = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [EVENT_W-1:0]   rsp_event_res;
   logic [MOTOR_W-1:0]   rsp_motor_cmd;
   logic                 rsp_door_locked;
   logic [DIGITS_W-1:0]  rsp_digits_entered;
   logic [FAIL_W-1:0]    rsp_failure_count;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CODE_W-1:0]    csr_wdata = '0;

   lock_scoreboard lock_sb = new();
   logic idle_on = 1'b1;
   int   stall_left = 0;
   int   cycle_count = 0;

   keypad_code_lock_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_side           (req_side),
      .req_key            (req_key),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_motor_cmd      (rsp_motor_cmd),
      .rsp_door_locked    (rsp_door_locked),
      .rsp_digits_entered (rsp_digits_entered),
      .rsp_failure_count  (rsp_failure_count),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side back-pressure in short random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 4) - 1;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         lock_sb.check_result(rsp_event_res, rsp_motor_cmd, rsp_door_locked,
                              rsp_digits_entered, rsp_failure_count);
   end

   // one key transaction, with an optional gap ahead of it
   task automatic press(input logic side, input logic [KEY_W-1:0] key);
      int gap;
      gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_side  = side;
      req_key   = key;
      do @(posedge clock); while (!req_ready);
      lock_sb.note_press(side, key);
   endtask

   // hold off until every predicted result has been taken
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (lock_sb.pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CODE_W-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      lock_sb.set_reg(idx, value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // key in a code digit by digit, most significant first, then enter
   task automatic enter_code(input logic side, input int unsigned code);
      int unsigned place;
      place = 1;
      repeat (CODE_DIGITS_DEF - 1) place *= 10;
      while (place != 0) begin
         press(side, KEY_W'((code / place) % 10));
         place /= 10;
      end
      press(side, KEY_ENTER);
   endtask

   // code made only of digits the keypad can enter
   function automatic logic [CODE_W-1:0] random_code();
      int unsigned value;
      value = 0;
      repeat (CODE_DIGITS_DEF) value = value * 10 + $urandom_range(1, 9);
      return value[CODE_W-1:0];
   endfunction

   // mostly real code entries, some wrong guesses, some stray keys
   task automatic run_random(input int n_keys);
      int   sent;
      int   pick;
      int   len;
      logic side;
      logic [KEY_W-1:0] key;
      sent = 0;
      while (sent < n_keys) begin
         pick = $urandom_range(0, 9);
         side = 1'($urandom_range(0, 1));
         if (pick < 5) begin
            enter_code(side, side ? lock_sb.close_code : lock_sb.open_code);
            sent += CODE_DIGITS_DEF + 1;
         end else if (pick < 8) begin
            len = $urandom_range(0, CODE_DIGITS_DEF + 1);
            repeat (len) press(side, KEY_W'($urandom_range(1, 9)));
            press(side, KEY_ENTER);
            sent += len + 1;
         end else begin
            key = KEY_W'($urandom_range(0, 15));
            press(side, key);
            if (key >= KEY_DIGIT_MIN && key <= KEY_ENTER) sent++;
         end
         if ($urandom_range(0, 80) == 0) wait_idle();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: open, repeat open, stray keys, full entry and close
      enter_code(1'b0, OPEN_CODE_RST);
      press(1'b0, KEY_ENTER);
      press(1'b0, 4'd0);
      press(1'b0, 4'd15);
      press(1'b0, 4'd11);
      press(1'b1, 4'd8);
      press(1'b1, 4'd7);
      press(1'b1, 4'd6);
      press(1'b1, 4'd5);
      press(1'b1, 4'd9);
      press(1'b1, KEY_ENTER);
      // short entry, wrong code, then enter at the limit and the alarm
      press(1'b1, 4'd1);
      press(1'b1, KEY_ENTER);
      enter_code(1'b0, 1234);
      press(1'b0, KEY_ENTER);
      press(1'b0, KEY_ENTER);
      press(1'b0, 4'd5);

      run_random(200);
      wait_idle();

      // codes out of reach and a zero limit
      write_reg(CSR_OPEN_CODE, 14'h3fff);
      write_reg(CSR_CLOSE_CODE, 14'd0);
      write_reg(CSR_MAX_FAILURES, 14'd0);
      write_reg(CSR_SPARE, 14'h2aaa);
      run_random(100);
      wait_idle();

      // widest limit, failure counter driven into saturation
      write_reg(CSR_OPEN_CODE, random_code());
      write_reg(CSR_CLOSE_CODE, random_code());
      write_reg(CSR_MAX_FAILURES, 14'd15);
      repeat (17) press(1'b1, KEY_ENTER);
      run_random(300);
      wait_idle();

      write_reg(CSR_OPEN_CODE, 14'd1111);
      write_reg(CSR_CLOSE_CODE, 14'd9999);
      write_reg(CSR_MAX_FAILURES, 14'd1);
      run_random(300);
      wait_idle();

      write_reg(CSR_OPEN_CODE, random_code());
      write_reg(CSR_CLOSE_CODE, random_code());
      write_reg(CSR_MAX_FAILURES, 14'($urandom_range(1, 15)));
      run_random(300);
      wait_idle();

      // last stretch at full rate on both channels
      idle_on = 1'b0;
      write_reg(CSR_OPEN_CODE, 14'd9999);
      write_reg(CSR_CLOSE_CODE, 14'd1111);
      write_reg(CSR_MAX_FAILURES, 14'd2);
      run_random(200);

      wait_idle();
      if (lock_sb.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: keypad_code_lock_top.f
+incdir+src
src/kcl_pkg.sv
src/kcl_core.sv
src/keypad_code_lock_top.sv
tb/keypad_code_lock_top_test.sv
